FILE: rtl/core/integer_interval_domain_store_assert.svh
// Assertion macros for the interval domain store
`ifndef INTEGER_INTERVAL_DOMAIN_STORE_ASSERT_SVH
`define INTEGER_INTERVAL_DOMAIN_STORE_ASSERT_SVH

// same-cycle implication
`define IIDS_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("interval store check failed");

// next-cycle implication
`define IIDS_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("interval store sequence check failed");

`endif

FILE: rtl/core/iids_pkg.sv
`default_nettype none
package iids_pkg;

    localparam int ENTRIES_DEF    = 256;
    localparam int VALUE_BITS_DEF = 54;

    localparam int OP_W   = 4;
    localparam int IDX_W  = 8;
    localparam int VAL_W  = 53;
    localparam int ST_W   = 2;
    localparam int NSZ_W  = 9;

    localparam logic signed [63:0] UPPER_RESET = 64'sd1 <<< 51;

    typedef enum logic [OP_W-1:0] {
        OP_REMOVE     = 4'd0,
        OP_ABOVE      = 4'd1,
        OP_BELOW      = 4'd2,
        OP_FIX        = 4'd3,
        OP_MIN_SIZE   = 4'd4,
        OP_MAX_SIZE   = 4'd5,
        OP_LOAD_ENTRY = 4'd6,
        OP_LOAD_SIZES = 4'd7,
        OP_QUERY      = 4'd8
    } t_op;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_INCONS   = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD_LOAD = 2'd2;

    typedef struct packed {
        logic [ST_W-1:0] status;
        logic            min_changed;
        logic            max_changed;
        logic            domain_changed;
        logic            bind_event;
        logic            size_changed;
    } t_flags;

endpackage
`default_nettype wire

FILE: rtl/core/integer_interval_domain_store.sv
// Channel  Dir  tuser          tdata (low bit first)
// s_*      in   op[3:0]        index[7:0] value[60:8] second_value[113:61] pad[119:114]
// m_*      out  status[1:0]    lower_bound[52:0] upper_bound[105:53] min_changed[106]
//                              max_changed[107] domain_changed[108] bind_event[109]
//                              size_changed[110] new_array_size[119:111]
//                              value_contained[120] entry_bound[121] entry_active[122]
// Each word steps through accept with bounds RAM read, execute with write-back,
// then result formation; the next word is taken the cycle after the result is formed.
// The step order is set by the registered RAM read feeding one read-modify-write per word.
// Reset is synchronous; per-entry valid bits stand in for the reset bounds, no clear pass.
// A stalled result holds the result register; one more word may be accepted, then it
// waits before result formation until the result register frees.
`default_nettype none
module integer_interval_domain_store
    import iids_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [119:0] s_tdata,  // index, value, second_value, zero pad
    input  wire logic [3:0]   s_tuser,  // op
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [127:0]      m_tdata,  // lower_bound, upper_bound, flags, new_array_size,
                                        // value_contained, entry_bound, entry_active
    output logic [1:0]        m_tuser   // status
);

    localparam int SW        = $clog2(ENTRIES + 1);
    localparam int MEM_DEPTH = (ENTRIES < 256) ? ENTRIES : 256;
    localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int WW        = (VALUE_BITS > 54) ? VALUE_BITS : 54;
    localparam logic [VALUE_BITS-1:0] UPPER_RST = UPPER_RESET[VALUE_BITS-1:0];

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_POST
    } t_state;

    t_state                         r_state;
    t_op                            r_op;
    logic                           r_ok;
    logic        [IDX_W-1:0]        r_idx;
    logic signed [VAL_W-1:0]        r_v, r_v2;
    logic signed [VALUE_BITS-1:0]   r_lo, r_hi;
    logic        [SW-1:0]           r_size_floor, r_size_ceil;
    logic        [NSZ_W-1:0]        r_nsz;
    t_flags                         r_flags;
    logic        [MEM_DEPTH-1:0]    r_vld;
    logic                           r_m_valid;
    logic        [127:0]            r_m_data;
    logic        [1:0]              r_m_user;

    logic                           s_acc;
    logic        [IDX_W-1:0]        s_idx;
    logic        [AW-1:0]           wr_addr;
    logic        [VALUE_BITS-1:0]   ram_lo_q, ram_hi_q;
    logic signed [VALUE_BITS-1:0]   rd_lo, rd_hi;
    logic                           ex_we, wr_en;
    logic signed [VALUE_BITS-1:0]   ex_lo, ex_hi;
    logic        [SW-1:0]           ex_min, ex_max;
    logic        [NSZ_W-1:0]        ex_nsz;
    t_flags                         ex_flags;
    logic                           ex_incons, ex_still;
    logic signed [WW-1:0]           p_lo, p_hi, p_v;
    logic                           p_cont, p_act, p_bound, out_free;
    logic        [127:0]            n_m_data;

    assign s_idx    = s_tdata[IDX_W-1:0];
    assign s_tready = r_state == S_IDLE;
    assign s_acc    = s_tvalid && s_tready;
    assign wr_addr  = r_idx[AW-1:0];
    assign wr_en    = ex_we && (r_state == S_EXEC);
    assign out_free = !r_m_valid || m_tready;

    iids_ram #(.WIDTH(VALUE_BITS), .DEPTH(MEM_DEPTH)) u_lo_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (ex_lo),
        .i_re    (s_acc),
        .i_raddr (s_idx[AW-1:0]),
        .o_rdata (ram_lo_q)
    );

    iids_ram #(.WIDTH(VALUE_BITS), .DEPTH(MEM_DEPTH)) u_hi_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (ex_hi),
        .i_re    (s_acc),
        .i_raddr (s_idx[AW-1:0]),
        .o_rdata (ram_hi_q)
    );

    assign rd_lo = r_vld[wr_addr] ? ram_lo_q : '0;
    assign rd_hi = r_vld[wr_addr] ? ram_hi_q : UPPER_RST;

    iids_exec #(.ENTRIES(ENTRIES), .VALUE_BITS(VALUE_BITS)) u_exec (
        .i_op         (r_op),
        .i_ok         (r_ok),
        .i_idx        (r_idx),
        .i_v          (r_v),
        .i_v2         (r_v2),
        .i_lo         (rd_lo),
        .i_hi         (rd_hi),
        .i_size_floor (r_size_floor),
        .i_size_ceil  (r_size_ceil),
        .o_we         (ex_we),
        .o_lo         (ex_lo),
        .o_hi         (ex_hi),
        .o_size_floor (ex_min),
        .o_size_ceil  (ex_max),
        .o_nsz        (ex_nsz),
        .o_flags      (ex_flags)
    );

    // result formation from the bounds and sizes left by the execute step
    assign p_lo    = WW'(r_lo);
    assign p_hi    = WW'(r_hi);
    assign p_v     = WW'(r_v);
    assign p_act   = WW'(r_idx) < WW'(r_size_floor);
    assign p_cont  = r_ok && (p_lo <= p_v) && (p_v <= p_hi);
    assign p_bound = r_ok && (p_lo == p_hi) && p_act;

    always_comb begin
        n_m_data          = '0;
        n_m_data[52:0]    = r_ok ? p_lo[VAL_W-1:0] : '0;
        n_m_data[105:53]  = r_ok ? p_hi[VAL_W-1:0] : '0;
        n_m_data[106]     = r_flags.min_changed;
        n_m_data[107]     = r_flags.max_changed;
        n_m_data[108]     = r_flags.domain_changed;
        n_m_data[109]     = r_flags.bind_event;
        n_m_data[110]     = r_flags.size_changed;
        n_m_data[119:111] = r_nsz;
        n_m_data[120]     = p_cont;
        n_m_data[121]     = p_bound;
        n_m_data[122]     = p_act;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_m_valid    <= 1'b0;
            r_size_floor <= SW'(ENTRIES);
            r_size_ceil  <= SW'(ENTRIES);
            r_vld        <= '0;
        end else begin
            if (r_state == S_POST && out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_size_floor <= ex_min;
                    r_size_ceil  <= ex_max;
                    if (wr_en) begin
                        r_vld[wr_addr] <= 1'b1;
                    end
                    r_state <= S_POST;
                end
                S_POST: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_op  <= t_op'(s_tuser);
            r_idx <= s_idx;
            r_ok  <= 32'(s_idx) < 32'(ENTRIES);
            r_v   <= s_tdata[60:8];
            r_v2  <= s_tdata[113:61];
        end
        if (r_state == S_EXEC) begin
            r_lo    <= ex_lo;
            r_hi    <= ex_hi;
            r_nsz   <= ex_nsz;
            r_flags <= ex_flags;
        end
        if (r_state == S_POST && out_free) begin
            r_m_data <= n_m_data;
            r_m_user <= r_flags.status;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;
    assign m_tuser  = r_m_user;

    assign ex_incons = (r_state == S_EXEC) && (ex_flags.status == ST_INCONS);
    assign ex_still  = !ex_we && (ex_min == r_size_floor) && (ex_max == r_size_ceil)
                       && !ex_flags.size_changed;

    `include "integer_interval_domain_store_assert.svh"

    `IIDS_ASSERT_IMP(a_size_order, i_clk, i_rst_n, 1'b1, r_size_floor <= r_size_ceil)
    `IIDS_ASSERT_IMP(a_write_in_exec, i_clk, i_rst_n, wr_en, r_state == S_EXEC && r_ok)
    `IIDS_ASSERT_NXT(a_accept_exec, i_clk, i_rst_n, s_acc, r_state == S_EXEC)
    `IIDS_ASSERT_IMP(a_incons_still, i_clk, i_rst_n, ex_incons, ex_still)

endmodule
`default_nettype wire

FILE: rtl/core/iids_ram.sv
`default_nettype none
module iids_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/iids_exec.sv
`default_nettype none
module iids_exec
    import iids_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    localparam int SW = $clog2(ENTRIES + 1)
) (
    input  wire t_op                           i_op,
    input  wire logic                          i_ok,
    input  wire logic        [IDX_W-1:0]       i_idx,
    input  wire logic signed [VAL_W-1:0]       i_v,
    input  wire logic signed [VAL_W-1:0]       i_v2,
    input  wire logic signed [VALUE_BITS-1:0]  i_lo,
    input  wire logic signed [VALUE_BITS-1:0]  i_hi,
    input  wire logic        [SW-1:0]          i_size_floor,
    input  wire logic        [SW-1:0]          i_size_ceil,
    output logic                               o_we,
    output logic signed      [VALUE_BITS-1:0]  o_lo,
    output logic signed      [VALUE_BITS-1:0]  o_hi,
    output logic             [SW-1:0]          o_size_floor,
    output logic             [SW-1:0]          o_size_ceil,
    output logic             [NSZ_W-1:0]       o_nsz,
    output t_flags                             o_flags
);

    localparam int WW = (VALUE_BITS > 54) ? VALUE_BITS : 54;
    localparam logic signed [WW-1:0] ENTRIES_W = WW'(ENTRIES);

    logic signed [WW-1:0] lo_w, hi_w, v_w, v2_w, v_m1, v_p1;
    logic signed [WW-1:0] idx_w, min_w, max_w;
    logic signed [WW-1:0] n_lo, n_hi;
    logic                 act, may, cont, eq;

    assign lo_w  = WW'(i_lo);
    assign hi_w  = WW'(i_hi);
    assign v_w   = WW'(i_v);
    assign v2_w  = WW'(i_v2);
    assign v_m1  = v_w - WW'(1);
    assign v_p1  = v_w + WW'(1);
    assign idx_w = $signed(WW'(i_idx));
    assign min_w = $signed(WW'(i_size_floor));
    assign max_w = $signed(WW'(i_size_ceil));

    assign act  = idx_w < min_w;
    assign may  = idx_w < max_w;
    assign cont = (lo_w <= v_w) && (v_w <= hi_w);
    assign eq   = lo_w == hi_w;

    assign o_lo = n_lo[VALUE_BITS-1:0];
    assign o_hi = n_hi[VALUE_BITS-1:0];

    always_comb begin
        n_lo         = lo_w;
        n_hi         = hi_w;
        o_we         = 1'b0;
        o_size_floor = i_size_floor;
        o_size_ceil  = i_size_ceil;
        o_nsz        = '0;
        o_flags      = '0;
        case (i_op)
            OP_REMOVE: begin
                if (i_ok && cont) begin
                    if (eq && act) begin
                        o_flags.status = ST_INCONS;
                    end else if (eq && may) begin
                        o_size_ceil          = SW'(i_idx);
                        o_nsz                = NSZ_W'(i_idx);
                        o_flags.size_changed = 1'b1;
                    end else begin
                        o_we = 1'b1;
                        if (v_w == hi_w) begin
                            n_hi                = v_m1;
                            o_flags.max_changed = 1'b1;
                        end else if (v_w == lo_w) begin
                            n_lo                = v_p1;
                            o_flags.min_changed = 1'b1;
                        end
                        o_flags.domain_changed = 1'b1;
                    end
                end
            end
            OP_ABOVE: begin
                if (i_ok) begin
                    if (lo_w > v_w && act) begin
                        o_flags.status = ST_INCONS;
                    end else if (lo_w > v_w && may) begin
                        o_size_ceil          = SW'(i_idx);
                        o_nsz                = NSZ_W'(i_idx);
                        o_flags.size_changed = 1'b1;
                    end else if (hi_w > v_w) begin
                        o_we                   = 1'b1;
                        n_hi                   = v_w;
                        o_flags.max_changed    = 1'b1;
                        o_flags.domain_changed = 1'b1;
                    end
                end
            end
            OP_BELOW: begin
                if (i_ok) begin
                    if (hi_w < v_w && act) begin
                        o_flags.status = ST_INCONS;
                    end else if (hi_w < v_w && may) begin
                        o_size_ceil          = SW'(i_idx);
                        o_nsz                = NSZ_W'(i_idx);
                        o_flags.size_changed = 1'b1;
                    end else if (lo_w < v_w) begin
                        o_we                   = 1'b1;
                        n_lo                   = v_w;
                        o_flags.min_changed    = 1'b1;
                        o_flags.domain_changed = 1'b1;
                    end
                end
            end
            OP_FIX: begin
                if (i_ok) begin
                    if (!cont && act) begin
                        o_flags.status = ST_INCONS;
                    end else if (!cont && may) begin
                        o_size_ceil          = SW'(i_idx);
                        o_nsz                = NSZ_W'(i_idx);
                        o_flags.size_changed = 1'b1;
                    end else if (!(cont && eq && act)) begin
                        o_we                   = 1'b1;
                        n_lo                   = v_w;
                        n_hi                   = v_w;
                        o_flags.min_changed    = v_w != lo_w;
                        o_flags.max_changed    = v_w != hi_w;
                        o_flags.domain_changed = 1'b1;
                        o_flags.bind_event     = 1'b1;
                    end
                end
            end
            OP_MIN_SIZE: begin
                if (v_w > max_w && !(v_w < min_w)) begin
                    o_flags.status = ST_INCONS;
                end else if (!(v_w < min_w) && v_w != min_w) begin
                    o_size_floor         = SW'(v_w);
                    o_nsz                = v_w[NSZ_W-1:0];
                    o_flags.size_changed = 1'b1;
                end
            end
            OP_MAX_SIZE: begin
                if (v_w < min_w && !(v_w > max_w)) begin
                    o_flags.status = ST_INCONS;
                end else if (!(v_w > max_w) && v_w != max_w) begin
                    o_size_ceil          = SW'(v_w);
                    o_nsz                = v_w[NSZ_W-1:0];
                    o_flags.size_changed = 1'b1;
                end
            end
            OP_LOAD_ENTRY: begin
                if (i_ok) begin
                    if (v_w > v2_w) begin
                        o_flags.status = ST_BAD_LOAD;
                    end else begin
                        o_we = 1'b1;
                        n_lo = v_w;
                        n_hi = v2_w;
                    end
                end
            end
            OP_LOAD_SIZES: begin
                if (v_w > v2_w || v_w[WW-1] || v2_w > ENTRIES_W) begin
                    o_flags.status = ST_BAD_LOAD;
                end else begin
                    o_size_floor = SW'(v_w);
                    o_size_ceil  = SW'(v2_w);
                end
            end
            default: begin
                o_we = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: dv/integer_interval_domain_store_tb.sv
module integer_interval_domain_store_tb;
    import iids_pkg::*;

    localparam longint V_MAX = (64'sd1 <<< 52) - 1;
    localparam longint V_MIN = -(64'sd1 <<< 52);
    localparam longint HI_RESET = UPPER_RESET;
    localparam logic [OP_W-1:0] OP_SPARE = 4'hF;
    localparam int RANDOM_WORDS = 1550;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_OFF = 300;
    localparam int PLAN_ROWS = 26;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [VAL_W-1:0] lower;
        logic [VAL_W-1:0] upper;
        logic             min_chg, max_chg, dom_chg, bind_ev, size_chg;
        logic [NSZ_W-1:0] new_size;
        logic             contained, bound, active;
    } t_outcome;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [IDX_W-1:0]   idx;
        logic signed [63:0] v;
        logic signed [63:0] v2;
        logic               typed;
        logic [ST_W-1:0]    status;
        logic signed [63:0] lower;
        logic signed [63:0] upper;
    } t_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [119:0] s_tdata = '0;  // index, value, second_value, zero pad
    logic [3:0]   s_tuser = '0;  // op
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;       // lower_bound, upper_bound, flags, new_array_size,
                                 // value_contained, entry_bound, entry_active
    logic [1:0]   m_tuser;       // status

    longint   lower_mem [ENTRIES_DEF];
    longint   upper_mem [ENTRIES_DEF];
    longint   size_floor;
    longint   size_ceil;
    logic     size_hit;
    longint   size_new;
    t_outcome pending_replies [$];
    int       errors = 0;
    int       sent = 0;
    int       checked = 0;
    int       cycles = 0;

    // directed words; typed rows carry status and bounds read straight off the spec
    t_row plan [PLAN_ROWS] = '{
        '{OP_QUERY,      0,   0,      0,     1, ST_OK,       0,     HI_RESET},
        '{OP_SPARE,      255, V_MIN,  0,     1, ST_OK,       0,     HI_RESET},
        '{OP_LOAD_ENTRY, 5,   10,     3,     1, ST_BAD_LOAD, 0,     HI_RESET},
        '{OP_LOAD_SIZES, 0,   5,      3,     1, ST_BAD_LOAD, 0,     HI_RESET},
        '{OP_LOAD_SIZES, 0,   -1,     10,    1, ST_BAD_LOAD, 0,     HI_RESET},
        '{OP_LOAD_SIZES, 0,   0,      257,   1, ST_BAD_LOAD, 0,     HI_RESET},
        '{OP_LOAD_ENTRY, 1,   V_MIN,  V_MAX, 1, ST_OK,       V_MIN, V_MAX},
        '{OP_REMOVE,     1,   V_MIN,  0,     0, ST_OK,       0,     0},
        '{OP_REMOVE,     1,   V_MAX,  0,     0, ST_OK,       0,     0},
        '{OP_LOAD_ENTRY, 255, V_MAX,  V_MAX, 1, ST_OK,       V_MAX, V_MAX},
        '{OP_ABOVE,      255, V_MIN,  0,     1, ST_INCONS,   V_MAX, V_MAX},
        '{OP_LOAD_ENTRY, 2,   7,      7,     1, ST_OK,       7,     7},
        '{OP_REMOVE,     2,   7,      0,     1, ST_INCONS,   7,     7},
        '{OP_BELOW,      3,   V_MAX,  0,     1, ST_INCONS,   0,     HI_RESET},
        '{OP_FIX,        3,   -5,     0,     1, ST_INCONS,   0,     HI_RESET},
        '{OP_LOAD_SIZES, 0,   4,      200,   1, ST_OK,       0,     HI_RESET},
        '{OP_LOAD_ENTRY, 100, 3,      3,     0, ST_OK,       0,     0},
        '{OP_REMOVE,     100, 3,      0,     0, ST_OK,       0,     0},
        '{OP_ABOVE,      150, -10,    0,     0, ST_OK,       0,     0},
        '{OP_BELOW,      50,  V_MAX,  0,     0, ST_OK,       0,     0},
        '{OP_FIX,        10,  20,     0,     0, ST_OK,       0,     0},
        '{OP_FIX,        10,  20,     0,     0, ST_OK,       0,     0},
        '{OP_MIN_SIZE,   0,   60,     0,     1, ST_INCONS,   0,     HI_RESET},
        '{OP_MAX_SIZE,   0,   2,      0,     1, ST_INCONS,   0,     HI_RESET},
        '{OP_MIN_SIZE,   0,   10,     0,     0, ST_OK,       0,     0},
        '{OP_LOAD_SIZES, 0,   256,    256,   1, ST_OK,       0,     HI_RESET}
    };

    integer_interval_domain_store dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic longint sext_value(logic [VAL_W-1:0] raw);
        logic signed [VAL_W-1:0] s;
        s = raw;
        return longint'(s);
    endfunction

    function automatic longint wrap_stored(longint x);
        logic signed [VALUE_BITS_DEF-1:0] s;
        s = x[VALUE_BITS_DEF-1:0];
        return longint'(s);
    endfunction

    function automatic logic [ST_W-1:0] shrink_ceil(longint n);
        if (n > size_ceil) return ST_OK;
        if (n < size_floor) return ST_INCONS;
        if (n != size_ceil) begin
            size_ceil = n;
            size_hit = 1'b1;
            size_new = n;
        end
        return ST_OK;
    endfunction

    function automatic logic [ST_W-1:0] raise_floor(longint n);
        if (n < size_floor) return ST_OK;
        if (n > size_ceil) return ST_INCONS;
        if (n != size_floor) begin
            size_floor = n;
            size_hit = 1'b1;
            size_new = n;
        end
        return ST_OK;
    endfunction

    function automatic t_outcome apply_domain_op(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                                 logic [VAL_W-1:0] raw_v,
                                                 logic [VAL_W-1:0] raw_v2);
        t_outcome r;
        longint   ix, v, v2, lo, hi;
        logic     act, may, cont;
        r = '0;
        ix = longint'(idx);
        v = sext_value(raw_v);
        v2 = sext_value(raw_v2);
        lo = lower_mem[idx];
        hi = upper_mem[idx];
        act = ix < size_floor;
        may = ix < size_ceil;
        cont = lo <= v && v <= hi;
        size_hit = 1'b0;
        size_new = 0;
        case (op)
            OP_REMOVE: begin
                if (cont) begin
                    if (lo == hi && act) begin
                        r.status = ST_INCONS;
                    end else if (lo == hi && may) begin
                        r.status = shrink_ceil(ix);
                    end else begin
                        if (v == hi) begin
                            upper_mem[idx] = wrap_stored(v - 1);
                            r.max_chg = 1'b1;
                        end else if (v == lo) begin
                            lower_mem[idx] = wrap_stored(v + 1);
                            r.min_chg = 1'b1;
                        end
                        r.dom_chg = 1'b1;
                    end
                end
            end
            OP_ABOVE: begin
                if (lo > v && act) begin
                    r.status = ST_INCONS;
                end else if (lo > v && may) begin
                    r.status = shrink_ceil(ix);
                end else if (hi > v) begin
                    upper_mem[idx] = wrap_stored(v);
                    r.max_chg = 1'b1;
                    r.dom_chg = 1'b1;
                end
            end
            OP_BELOW: begin
                if (hi < v && act) begin
                    r.status = ST_INCONS;
                end else if (hi < v && may) begin
                    r.status = shrink_ceil(ix);
                end else if (lo < v) begin
                    lower_mem[idx] = wrap_stored(v);
                    r.min_chg = 1'b1;
                    r.dom_chg = 1'b1;
                end
            end
            OP_FIX: begin
                if (!cont && act) begin
                    r.status = ST_INCONS;
                end else if (!cont && may) begin
                    r.status = shrink_ceil(ix);
                end else if (!(cont && lo == hi && act)) begin
                    r.min_chg = v != lo;
                    r.max_chg = v != hi;
                    lower_mem[idx] = wrap_stored(v);
                    upper_mem[idx] = wrap_stored(v);
                    r.dom_chg = 1'b1;
                    r.bind_ev = 1'b1;
                end
            end
            OP_MIN_SIZE: r.status = raise_floor(v);
            OP_MAX_SIZE: r.status = shrink_ceil(v);
            OP_LOAD_ENTRY: begin
                if (v > v2) begin
                    r.status = ST_BAD_LOAD;
                end else begin
                    lower_mem[idx] = wrap_stored(v);
                    upper_mem[idx] = wrap_stored(v2);
                end
            end
            OP_LOAD_SIZES: begin
                if (v > v2 || v < 0 || v2 > ENTRIES_DEF) begin
                    r.status = ST_BAD_LOAD;
                end else begin
                    size_floor = v;
                    size_ceil = v2;
                end
            end
            default: ;
        endcase
        r.size_chg = size_hit;
        r.new_size = size_new[NSZ_W-1:0];
        act = ix < size_floor;
        lo = lower_mem[idx];
        hi = upper_mem[idx];
        r.lower = lo[VAL_W-1:0];
        r.upper = hi[VAL_W-1:0];
        r.contained = lo <= v && v <= hi;
        r.bound = lo == hi && act;
        r.active = act;
        return r;
    endfunction

    function automatic longint random_word();
        longint x;
        x = {$urandom, $urandom};
        return x;
    endfunction

    function automatic longint near_bounds(longint lo, longint hi);
        longint span, x;
        span = hi - lo;
        case ($urandom_range(9))
            0: x = lo;
            1: x = hi;
            2: x = lo + 1;
            3: x = hi - 1;
            4: x = lo - 1;
            5: x = hi + 1;
            6: begin
                if (span >= 0 && span < 4096) x = lo + longint'($urandom_range(int'(span)));
                else x = lo + longint'($urandom_range(15));
            end
            7: x = random_word();
            8: x = ($urandom_range(1) == 0) ? V_MIN : V_MAX;
            default: x = longint'($urandom_range(60)) - 30;
        endcase
        return x;
    endfunction

    function automatic t_row random_row();
        t_row   r;
        int     pick;
        longint base;
        r = '0;
        pick = int'($urandom_range(99));
        r.idx = IDX_W'(($urandom_range(9) < 7) ? $urandom_range(47) : $urandom_range(255));
        // reopen the sizes once most entries have fallen out of range
        if (size_ceil < 8 && pick < 90) pick = 95;
        r.v2 = random_word();
        if (pick < 15) r.op = OP_REMOVE;
        else if (pick < 27) r.op = OP_ABOVE;
        else if (pick < 39) r.op = OP_BELOW;
        else if (pick < 51) r.op = OP_FIX;
        else if (pick < 59) r.op = OP_MIN_SIZE;
        else if (pick < 67) r.op = OP_MAX_SIZE;
        else if (pick < 82) r.op = OP_LOAD_ENTRY;
        else if (pick < 88) r.op = OP_QUERY;
        else if (pick < 90) r.op = OP_W'($urandom_range(OP_SPARE, OP_QUERY + 1));
        else r.op = OP_LOAD_SIZES;
        case (r.op)
            OP_MIN_SIZE, OP_MAX_SIZE: begin
                case ($urandom_range(4))
                    0: r.v = random_word();
                    1: r.v = size_floor - 1 + longint'($urandom_range(2));
                    2: r.v = size_ceil - 1 + longint'($urandom_range(2));
                    default: r.v = longint'($urandom_range(ENTRIES_DEF + 1));
                endcase
            end
            OP_LOAD_ENTRY: begin
                base = longint'($urandom_range(40)) - 20;
                case ($urandom_range(9))
                    0: begin
                        r.v = random_word();
                        r.v2 = random_word();
                    end
                    1: begin
                        r.v = base;
                        r.v2 = base - 1 - longint'($urandom_range(3));
                    end
                    2: begin
                        r.v = V_MIN + longint'($urandom_range(3));
                        r.v2 = r.v + longint'($urandom_range(3));
                    end
                    3: begin
                        r.v = V_MAX - longint'($urandom_range(3));
                        r.v2 = V_MAX;
                    end
                    default: begin
                        r.v = base;
                        r.v2 = base + longint'($urandom_range(6));
                    end
                endcase
            end
            OP_LOAD_SIZES: begin
                case ($urandom_range(9))
                    0: begin
                        r.v = random_word();
                        r.v2 = random_word();
                    end
                    1: begin
                        r.v = -1 - longint'($urandom_range(3));
                        r.v2 = longint'($urandom_range(ENTRIES_DEF));
                    end
                    2: begin
                        r.v = longint'($urandom_range(ENTRIES_DEF));
                        r.v2 = ENTRIES_DEF + 1 + longint'($urandom_range(3));
                    end
                    3: begin
                        r.v = longint'(ENTRIES_DEF);
                        r.v2 = longint'(ENTRIES_DEF);
                    end
                    4: begin
                        r.v2 = longint'($urandom_range(40));
                        r.v = r.v2 + 1 + longint'($urandom_range(5));
                    end
                    default: begin
                        r.v = longint'($urandom_range(40));
                        r.v2 = longint'($urandom_range(ENTRIES_DEF, int'(r.v)));
                    end
                endcase
            end
            default: r.v = near_bounds(lower_mem[r.idx], upper_mem[r.idx]);
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        errors++;
        if (errors <= 100)
            $display("word %0d: %s is %0h, want %0h", checked, field, got, want);
    endtask

    task automatic send_word(t_row w);
        int       gap;
        t_outcome want;
        gap = ((sent % 256) < 40) ? 0 : int'($urandom_range(19));
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= w.op;
        s_tdata <= {6'd0, w.v2[VAL_W-1:0], w.v[VAL_W-1:0], w.idx};
        do @(posedge i_clk); while (!s_tready);
        want = apply_domain_op(w.op, w.idx, w.v[VAL_W-1:0], w.v2[VAL_W-1:0]);
        if (w.typed) begin
            want.status = w.status;
            want.lower = w.lower[VAL_W-1:0];
            want.upper = w.upper[VAL_W-1:0];
        end
        pending_replies.push_back(want);
        sent++;
    endtask

    initial begin
        int i;
        for (i = 0; i < ENTRIES_DEF; i++) begin
            lower_mem[i] = 0;
            upper_mem[i] = wrap_stored(HI_RESET);
        end
        size_floor = longint'(ENTRIES_DEF);
        size_ceil = longint'(ENTRIES_DEF);
    end

    initial begin
        int k;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (k = 0; k < PLAN_ROWS; k++) send_word(plan[k]);
        for (k = 0; k < RANDOM_WORDS; k++) send_word(random_row());
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (errors == 0) begin
            $display("** integer_interval_domain_store: PASSED **");
        end else begin
            $display("** integer_interval_domain_store: FAILED **");
        end
        $finish;
    end

    // result side: random stalls, bursts of none, and one long hold-off to back up the pipe
    initial begin
        int stall;
        int taken;
        bit held;
        taken = 0;
        held = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = ((taken % 256) < 40) ? 0 : int'($urandom_range(19));
            if (!held && taken >= 500) begin
                stall = HOLD_OFF;
                held = 1'b1;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
            taken++;
        end
    end

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_replies.size() == 0) begin
                report_mismatch("unrequested word, lower_bound", 64'(m_tdata[52:0]), 64'(0));
            end else begin
                want = pending_replies.pop_front();
                if (m_tuser !== want.status)
                    report_mismatch("status", 64'(m_tuser), 64'(want.status));
                if (m_tdata[52:0] !== want.lower)
                    report_mismatch("lower_bound", 64'(m_tdata[52:0]), 64'(want.lower));
                if (m_tdata[105:53] !== want.upper)
                    report_mismatch("upper_bound", 64'(m_tdata[105:53]), 64'(want.upper));
                if (m_tdata[106] !== want.min_chg)
                    report_mismatch("min_changed", 64'(m_tdata[106]), 64'(want.min_chg));
                if (m_tdata[107] !== want.max_chg)
                    report_mismatch("max_changed", 64'(m_tdata[107]), 64'(want.max_chg));
                if (m_tdata[108] !== want.dom_chg)
                    report_mismatch("domain_changed", 64'(m_tdata[108]), 64'(want.dom_chg));
                if (m_tdata[109] !== want.bind_ev)
                    report_mismatch("bind_event", 64'(m_tdata[109]), 64'(want.bind_ev));
                if (m_tdata[110] !== want.size_chg)
                    report_mismatch("size_changed", 64'(m_tdata[110]), 64'(want.size_chg));
                if (m_tdata[119:111] !== want.new_size)
                    report_mismatch("new_array_size", 64'(m_tdata[119:111]),
                                    64'(want.new_size));
                if (m_tdata[120] !== want.contained)
                    report_mismatch("value_contained", 64'(m_tdata[120]),
                                    64'(want.contained));
                if (m_tdata[121] !== want.bound)
                    report_mismatch("entry_bound", 64'(m_tdata[121]), 64'(want.bound));
                if (m_tdata[122] !== want.active)
                    report_mismatch("entry_active", 64'(m_tdata[122]), 64'(want.active));
            end
            checked++;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("** integer_interval_domain_store: FAILED **");
            $finish;
        end
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/iids_pkg.sv
rtl/core/iids_ram.sv
rtl/core/iids_exec.sv
rtl/core/integer_interval_domain_store.sv
dv/integer_interval_domain_store_tb.sv
